[design/itoa_pkg.sv]
// shared constants and helpers for the integer to ascii formatter
// no dependencies; imported by the channel interfaces, the formatter, the checker and the testbench
`default_nettype none

package itoa_pkg;

    localparam int VALUE_W    = 32;
    localparam int FWIDTH_W   = 5;
    localparam int CHAR_W     = 8;
    localparam int DIGIT_W    = 4;
    localparam int BCD_DIGITS = 10;
    localparam int HEX_DIGITS = 8;
    localparam int DIGITS_W   = BCD_DIGITS * DIGIT_W;
    localparam int NDIG_W     = 4;
    localparam int BITCNT_W   = 5;

    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_HEX_OFS = 8'h57;  // 'a' - 10
    localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2d;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] dx;
        dx = {{(CHAR_W-DIGIT_W){1'b0}}, d};
        if (d < 4'd10) begin
            return CH_ZERO + dx;
        end else begin
            return CH_HEX_OFS + dx;
        end
    endfunction

endpackage

`default_nettype wire

[design/itoa_if.sv]
// valid/ready channel interfaces for the formatter: number in, characters out
// depends on itoa_pkg for field widths
`default_nettype none

interface itoa_in_if
    import itoa_pkg::*;
    ();
    logic                valid;
    logic                ready;
    logic [VALUE_W-1:0]  value;
    logic                is_signed;
    logic                hex_base;
    logic [FWIDTH_W-1:0] field_width;
    logic                zero_pad;

    modport source (output valid, value, is_signed, hex_base, field_width, zero_pad,
                    input ready);
    modport sink   (input valid, value, is_signed, hex_base, field_width, zero_pad,
                    output ready);
endinterface

interface itoa_out_if
    import itoa_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] character;
    logic              last_char;

    modport source (output valid, character, last_char, input ready);
    modport sink   (input valid, character, last_char, output ready);
endinterface

`default_nettype wire

[design/int_to_ascii_padded.sv]
// integer to ascii formatter: signed/unsigned decimal or lower-case hex, padded
// depends on itoa_pkg and the channel interfaces in itoa_if.sv
//
//  channel | dir | handshake   | beat payload
//  i_in    | in  | valid/ready | value, is_signed, hex_base, field_width, zero_pad
//  o_out   | out | valid/ready | character, last_char
//
// decimal: bit-serial double dabble over all 32 bits, then dropping up to 9 leading
// zero digits, then the characters are sent out (hex skips the dabble)
// i_rst_n is synchronous; it clears the state and the output valid
// a stalled output beat holds; i_in.ready is high only between numbers
`default_nettype none

module int_to_ascii_padded
    import itoa_pkg::*;
#(
    parameter int MAX_WIDTH = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    itoa_in_if.sink     i_in,
    itoa_out_if.source  o_out
);

    localparam int WW_RAW = $clog2(MAX_WIDTH + 1);
    localparam int CW     = (WW_RAW > FWIDTH_W) ? WW_RAW : FWIDTH_W;
    localparam logic [CW-1:0] MAX_W = CW'(MAX_WIDTH);

    typedef enum logic [2:0] {
        ST_IDLE, ST_CONV, ST_NORM, ST_FILL, ST_SIGN, ST_DIG
    } t_state;

    t_state               r_state;
    logic [VALUE_W-1:0]   r_mag;
    logic [DIGITS_W-1:0]  r_digits;
    logic [DIGITS_W-1:0]  n_digits;
    logic [BITCNT_W-1:0]  r_bitcnt;
    logic [NDIG_W-1:0]    r_ndig;
    logic                 r_neg;
    logic [CW-1:0]        r_width;
    logic [CW-1:0]        r_fill;
    logic [CHAR_W-1:0]    r_fill_ch;
    logic                 r_out_valid;
    logic [CHAR_W-1:0]    r_out_char;
    logic                 r_out_last;

    logic                 in_neg;
    logic [VALUE_W-1:0]   in_mag;
    logic [CW-1:0]        in_width;
    logic [CW-1:0]        text_len;
    logic                 slot_free;
    logic                 emit;

    assign i_in.ready      = (r_state == ST_IDLE);
    assign o_out.valid     = r_out_valid;
    assign o_out.character = r_out_char;
    assign o_out.last_char = r_out_last;

    assign slot_free = !r_out_valid || o_out.ready;

    // a new output beat is loaded this cycle
    assign emit = slot_free && ((r_state == ST_FILL && r_fill != '0) ||
                                r_state == ST_SIGN || r_state == ST_DIG);

    assign in_neg   = !i_in.hex_base && i_in.is_signed && i_in.value[VALUE_W-1];
    assign in_mag   = in_neg ? (~i_in.value + 32'd1) : i_in.value;
    assign in_width = (CW'(i_in.field_width) > MAX_W) ? MAX_W : CW'(i_in.field_width);
    assign text_len = CW'(r_ndig) + CW'(r_neg);

    // one double dabble step: correct each bcd digit, then shift in the next bit
    always_comb begin
        logic [DIGITS_W-1:0] adj;
        adj = r_digits;
        for (int d = 0; d < BCD_DIGITS; d++) begin
            if (r_digits[d*DIGIT_W +: DIGIT_W] >= 4'd5) begin
                adj[d*DIGIT_W +: DIGIT_W] = r_digits[d*DIGIT_W +: DIGIT_W] + 4'd3;
            end
        end
        n_digits = {adj[DIGITS_W-2:0], r_mag[VALUE_W-1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in.valid) begin
                        r_neg     <= in_neg;
                        r_width   <= in_width;
                        r_fill_ch <= i_in.zero_pad ? CH_ZERO : CH_SPACE;
                        r_mag     <= in_mag;
                        r_bitcnt  <= '0;
                        if (i_in.hex_base) begin
                            r_digits <= {in_mag, {(DIGITS_W-VALUE_W){1'b0}}};
                            r_ndig   <= NDIG_W'(HEX_DIGITS);
                            r_state  <= ST_NORM;
                        end else begin
                            r_digits <= '0;
                            r_state  <= ST_CONV;
                        end
                    end
                end
                ST_CONV: begin
                    r_digits <= n_digits;
                    r_mag    <= {r_mag[VALUE_W-2:0], 1'b0};
                    r_bitcnt <= r_bitcnt + 1'b1;
                    if (r_bitcnt == BITCNT_W'(VALUE_W - 1)) begin
                        r_ndig  <= NDIG_W'(BCD_DIGITS);
                        r_state <= ST_NORM;
                    end
                end
                ST_NORM: begin
                    // drop leading zero digits, keeping at least one
                    if (r_digits[DIGITS_W-1 -: DIGIT_W] == '0 && r_ndig > 4'd1) begin
                        r_digits <= {r_digits[DIGITS_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                        r_ndig   <= r_ndig - 1'b1;
                    end else begin
                        r_fill  <= (r_width > text_len) ? (r_width - text_len) : '0;
                        r_state <= ST_FILL;
                    end
                end
                ST_FILL: begin
                    if (r_fill == '0) begin
                        r_state <= r_neg ? ST_SIGN : ST_DIG;
                    end else if (slot_free) begin
                        r_out_char  <= r_fill_ch;
                        r_out_last  <= 1'b0;
                        r_fill      <= r_fill - 1'b1;
                    end
                end
                ST_SIGN: begin
                    if (slot_free) begin
                        r_out_char  <= CH_MINUS;
                        r_out_last  <= 1'b0;
                        r_state     <= ST_DIG;
                    end
                end
                ST_DIG: begin
                    if (slot_free) begin
                        r_out_char  <= digit_to_ascii(r_digits[DIGITS_W-1 -: DIGIT_W]);
                        r_out_last  <= (r_ndig == 4'd1);
                        r_digits    <= {r_digits[DIGITS_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                        r_ndig      <= r_ndig - 1'b1;
                        if (r_ndig == 4'd1) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

[tb/sv/itoa_text_checker.sv]
// watches both channels of the formatter, predicts the text of each number and compares
// depends on itoa_pkg for widths and character codes
module itoa_text_checker
    import itoa_pkg::*;
#(
    parameter int MAX_WIDTH = 16
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    input  wire                i_in_ready,
    input  wire [VALUE_W-1:0]  i_value,
    input  wire                i_is_signed,
    input  wire                i_hex_base,
    input  wire [FWIDTH_W-1:0] i_field_width,
    input  wire                i_zero_pad,
    input  wire                i_out_valid,
    input  wire                i_out_ready,
    input  wire [CHAR_W-1:0]   i_character,
    input  wire                i_last_char,
    output int                 o_pending,
    output int                 o_errors
);

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last_char;
    } t_char_beat;

    t_char_beat expected_chars[$];
    t_char_beat head;
    int         errors = 0;
    int         chars_seen = 0;

    assign o_errors = errors;

    task automatic report_mismatch(input string msg);
        $display("mismatch at char %0d (t=%0t): %s", chars_seen, $time, msg);
        errors++;
    endtask

    // builds the characters of one number and queues them in output order
    function automatic void predict_text(input logic [VALUE_W-1:0]  value,
                                         input logic                sgn,
                                         input logic                hex,
                                         input logic [FWIDTH_W-1:0] width,
                                         input logic                zpad);
        logic [CHAR_W-1:0]  text[$];
        logic [VALUE_W-1:0] mag;
        logic [DIGIT_W-1:0] d;
        logic               neg;
        logic [CHAR_W-1:0]  fill_ch;
        t_char_beat         beat;
        int                 w;
        int                 fill;
        int                 total;
        int                 k;
        neg = !hex && sgn && value[VALUE_W-1];
        mag = neg ? -value : value;
        do begin
            if (hex) begin
                d   = mag[DIGIT_W-1:0];
                mag = mag >> DIGIT_W;
            end else begin
                d   = DIGIT_W'(mag % 10);
                mag = mag / 10;
            end
            text.push_front(d < 10 ? CH_ZERO + CHAR_W'(d) : CH_HEX_OFS + CHAR_W'(d));
        end while (mag != 0);
        if (neg) begin
            text.push_front(CH_MINUS);
        end
        w       = (int'(width) > MAX_WIDTH) ? MAX_WIDTH : int'(width);
        fill    = (w > text.size()) ? w - text.size() : 0;
        total   = fill + text.size();
        fill_ch = zpad ? CH_ZERO : CH_SPACE;
        // fill goes in front of the sign
        for (k = 0; k < total; k++) begin
            beat.character = (k < fill) ? fill_ch : text[k - fill];
            beat.last_char = (k == total - 1);
            expected_chars.push_back(beat);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_chars.delete();
            o_pending <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_chars.size() == 0) begin
                    report_mismatch($sformatf("character 0x%02h with nothing expected",
                                              i_character));
                end else begin
                    head = expected_chars.pop_front();
                    if (i_character !== head.character) begin
                        report_mismatch($sformatf("character 0x%02h, expected 0x%02h",
                                                  i_character, head.character));
                    end
                    if (i_last_char !== head.last_char) begin
                        report_mismatch($sformatf("last_char %b, expected %b",
                                                  i_last_char, head.last_char));
                    end
                end
                chars_seen++;
            end
            if (i_in_valid && i_in_ready) begin
                predict_text(i_value, i_is_signed, i_hex_base, i_field_width, i_zero_pad);
            end
            o_pending <= expected_chars.size();
        end
    end

endmodule

[tb/sv/tb.sv]
// top of the formatter testbench: clock, reset, number stimulus, sink stalls, verdict
// depends on itoa_pkg, the channel interfaces, int_to_ascii_padded and itoa_text_checker
module tb;
    import itoa_pkg::*;

    localparam int FIELD_MAX  = 16;
    localparam int IDLE_LIMIT = 5000;
    localparam int RANDOM_N   = 280;
    localparam int TAIL_CYCLES = 60;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   pending;
    int   errors;
    int   idle_cycles = 0;
    int   sink_stall = 0;
    bit   calm = 1'b0;

    itoa_in_if  in_ch ();
    itoa_out_if out_ch ();

    int_to_ascii_padded #(.MAX_WIDTH(FIELD_MAX)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    itoa_text_checker #(.MAX_WIDTH(FIELD_MAX)) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_ch.valid),
        .i_in_ready    (in_ch.ready),
        .i_value       (in_ch.value),
        .i_is_signed   (in_ch.is_signed),
        .i_hex_base    (in_ch.hex_base),
        .i_field_width (in_ch.field_width),
        .i_zero_pad    (in_ch.zero_pad),
        .i_out_valid   (out_ch.valid),
        .i_out_ready   (out_ch.ready),
        .i_character   (out_ch.character),
        .i_last_char   (out_ch.last_char),
        .o_pending     (pending),
        .o_errors      (errors)
    );

    always #1 i_clk = ~i_clk;

    // mostly short gaps, now and then a long one, none while calm
    function automatic int pick_gap();
        int r;
        if (calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return $urandom_range(0, 255);
            2: return -VALUE_W'($urandom_range(1, 1000));
            3: begin
                case ($urandom_range(0, 5))
                    0: return 32'h0000_0000;
                    1: return 32'hffff_ffff;
                    2: return 32'h8000_0000;
                    3: return 32'h7fff_ffff;
                    4: return 32'd1_000_000_000;
                    default: return 32'd999_999_999;
                endcase
            end
            default: return $urandom >> $urandom_range(0, 31);
        endcase
    endfunction

    task automatic send_number(input logic [VALUE_W-1:0]  value,
                               input logic                sgn,
                               input logic                hex,
                               input logic [FWIDTH_W-1:0] width,
                               input logic                zpad);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.value       <= value;
        in_ch.is_signed   <= sgn;
        in_ch.hex_base    <= hex;
        in_ch.field_width <= width;
        in_ch.zero_pad    <= zpad;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic wait_drained();
        do @(posedge i_clk); while (pending != 0);
    endtask

    // sink side stalls
    always @(posedge i_clk) begin
        if (sink_stall > 0) begin
            out_ch.ready <= 1'b0;
            sink_stall   <= sink_stall - 1;
        end else if (!calm && $urandom_range(0, 3) == 0) begin
            out_ch.ready <= 1'b0;
            sink_stall   <= pick_gap();
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // watchdog on cycles where neither channel moves a beat
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        i_rst_n           <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.value       <= '0;
        in_ch.is_signed   <= 1'b0;
        in_ch.hex_base    <= 1'b0;
        in_ch.field_width <= '0;
        in_ch.zero_pad    <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero in every mode
        send_number(32'h0000_0000, 1'b0, 1'b0, 5'd0,  1'b0);
        send_number(32'h0000_0000, 1'b1, 1'b0, 5'd3,  1'b1);
        send_number(32'h0000_0000, 1'b0, 1'b1, 5'd2,  1'b0);
        // all ones: largest unsigned, minus one, full hex
        send_number(32'hffff_ffff, 1'b0, 1'b0, 5'd0,  1'b0);
        send_number(32'hffff_ffff, 1'b1, 1'b0, 5'd5,  1'b0);
        send_number(32'hffff_ffff, 1'b0, 1'b1, 5'd31, 1'b1);
        // most negative value at exact and wider width and unsigned view; largest positive
        send_number(32'h8000_0000, 1'b1, 1'b0, 5'd11, 1'b1);
        send_number(32'h8000_0000, 1'b1, 1'b0, 5'd16, 1'b0);
        send_number(32'h8000_0000, 1'b0, 1'b0, 5'd0,  1'b0);
        send_number(32'h7fff_ffff, 1'b1, 1'b0, 5'd10, 1'b1);
        // hex wins over signed
        send_number(32'hfedc_ba98, 1'b1, 1'b1, 5'd9,  1'b1);
        send_number(32'hffff_fffb, 1'b1, 1'b1, 5'd0,  1'b0);
        // fill lands in front of the sign
        send_number(32'hffff_fffb, 1'b1, 1'b0, 5'd4,  1'b1);
        send_number(32'hffff_fffb, 1'b1, 1'b0, 5'd4,  1'b0);
        // widths beyond the cap saturate
        send_number(32'd7,         1'b0, 1'b0, 5'd17, 1'b0);
        send_number(32'd42,        1'b0, 1'b0, 5'd31, 1'b1);
        send_number(32'hcafe_f00d, 1'b0, 1'b1, 5'd16, 1'b0);
        // width at or below text length never cuts; then wider fields
        send_number(32'd1_000_000_000, 1'b0, 1'b0, 5'd3, 1'b1);
        send_number(32'habcd_ef12, 1'b0, 1'b1, 5'd1,  1'b0);
        send_number(32'd9,         1'b0, 1'b0, 5'd1,  1'b1);
        send_number(32'd10,        1'b1, 1'b0, 5'd2,  1'b0);
        send_number(32'd99,        1'b0, 1'b0, 5'd15, 1'b0);
        send_number(32'h0000_000f, 1'b0, 1'b1, 5'd8,  1'b1);

        for (int n = 0; n < RANDOM_N; n++) begin
            calm = (n >= 100 && n < 140);
            if (n == 150 || n == 220) begin
                in_ch.valid <= 1'b0;
                wait_drained();
            end
            send_number(pick_value(), 1'($urandom), ($urandom_range(0, 2) == 0),
                        ($urandom_range(0, 9) < 8) ? FWIDTH_W'($urandom_range(0, 16))
                                                   : FWIDTH_W'($urandom_range(17, 31)),
                        1'($urandom));
        end
        in_ch.valid <= 1'b0;
        calm = 1'b0;

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
